FILE: rtl/awm_pkg.sv
// ----------------------------------------------------------------------------
// awm_pkg
// Shared types, codes and helpers of the anagram window matcher.
// ----------------------------------------------------------------------------
package awm_pkg;

  localparam int SYM_W     = 8;
  localparam int SYM_COUNT = 256;
  localparam int TOTAL_W   = 9;
  localparam int START_W   = 32;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_TEXT    = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  // one count table entry: pattern membership plus signed remaining count
  typedef struct packed {
    logic              member;
    logic signed [7:0] need;
  } cnt_entry_t;

  // count table port: one read and one write per cycle
  typedef struct packed {
    logic             rd_en;
    logic [SYM_W-1:0] rd_addr;
    logic             wr_en;
    logic [SYM_W-1:0] wr_addr;
    cnt_entry_t       wr_data;
  } cnt_req_t;

  function automatic logic signed [7:0] sat_inc(input logic signed [7:0] v);
    return (v == 8'sd127) ? v : v + 8'sd1;
  endfunction

  function automatic logic signed [7:0] sat_dec(input logic signed [7:0] v);
    return (v == -8'sd128) ? v : v - 8'sd1;
  endfunction

endpackage

FILE: rtl/awm_count_table.sv
// ----------------------------------------------------------------------------
// awm_count_table
// Per-byte count table: synchronous memory with a registered read, per-entry
// valid flops so a clear empties every entry at once, write-to-read forwarding.
// ----------------------------------------------------------------------------
module awm_count_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clr_i,
  input  awm_pkg::cnt_req_t    req_i,
  output awm_pkg::cnt_entry_t  rd_data_o
);

  awm_pkg::cnt_entry_t mem_q [awm_pkg::SYM_COUNT];
  logic [awm_pkg::SYM_COUNT-1:0] valid_q;

  awm_pkg::cnt_entry_t rd_mem_q;
  awm_pkg::cnt_entry_t fwd_data_q;
  logic                fwd_q;
  logic                vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_mem_q   <= mem_q[req_i.rd_addr];
      fwd_data_q <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fwd_q   <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      // clear wins over a write landing in the same cycle
      if (clr_i) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        fwd_q <= req_i.wr_en && (req_i.wr_addr == req_i.rd_addr);
        vld_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  // entries never written since clear read as zero
  assign rd_data_o = fwd_q ? fwd_data_q : (vld_q ? rd_mem_q : '0);

endmodule

FILE: rtl/anagram_window_matcher_core.sv
// ----------------------------------------------------------------------------
// anagram_window_matcher_core
// Sliding-window anagram search over a byte stream.
// ----------------------------------------------------------------------------
// Items are clear, pattern byte or text byte. Each text byte gives one result
// (found, start_index) through stage 2 and the output register; other kinds
// give none. A pattern or text byte holds off the next item while it is in
// stage 2; clear and ignored items do not. This is set by the single-port
// count table: a text byte reads and updates the entering byte's entry, then
// the leaving byte's entry, which overlaps with the next item. A new item is
// taken only when the output register is empty or drained in the same cycle.
// Clear resets the whole table at once; no clearing pass is needed after reset.
module anagram_window_matcher_core #(
  parameter int PATTERN_MAX = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [awm_pkg::SYM_W-1:0]     symbol_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [awm_pkg::START_W-1:0]   start_index_o
);

  localparam int HW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LW = $clog2(PATTERN_MAX + 1);

  typedef enum logic [1:0] {
    OP_PATTERN = 2'd0,
    OP_TEXT    = 2'd1,
    OP_EMPTY   = 2'd2
  } s2_op_e;

  // scalar state
  logic [LW-1:0]                  plen_q, plen_d;
  logic [LW-1:0]                  fill_q, fill_d;
  logic [HW-1:0]                  ring_q, ring_d;
  logic [awm_pkg::START_W-1:0]    start_q, start_d;
  logic [awm_pkg::TOTAL_W-1:0]    matched_q, matched_d;
  logic [awm_pkg::TOTAL_W-1:0]    distinct_q, distinct_d;

  // second stage
  logic                           s2_valid_q;
  s2_op_e                         s2_op_q;
  logic [awm_pkg::SYM_W-1:0]      s2_sym_q;
  logic                           s2_leave_q;
  logic                           s2_fwd_hist_q;
  logic [awm_pkg::START_W-1:0]    s2_start_q;
  logic                           s3_valid_q;

  logic                           out_valid_q;
  logic                           out_found_q;
  logic [awm_pkg::START_W-1:0]    out_start_q;

  logic [awm_pkg::SYM_W-1:0]      hist_mem [PATTERN_MAX];
  logic [awm_pkg::SYM_W-1:0]      hist_rd_q;

  awm_pkg::cnt_req_t              cnt_req;
  awm_pkg::cnt_entry_t            cnt_rd;

  logic                           accept;
  logic                           acc_clear, acc_pat, acc_text, acc_run;
  logic                           slide;
  logic [HW:0]                    slot_sum;
  logic [HW-1:0]                  slot;
  logic [HW-1:0]                  ring_next;
  logic [awm_pkg::SYM_W-1:0]      leave_sym;
  logic                           s2_result;

  awm_pkg::cnt_entry_t            pat_entry, txt_entry, lv_entry;
  logic [awm_pkg::TOTAL_W-1:0]    pat_matched, pat_distinct, txt_matched, lv_matched;
  logic                           txt_found;

  assign in_stall_o = s2_valid_q || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    acc_clear = 1'b0;
    acc_pat   = 1'b0;
    acc_text  = 1'b0;
    unique case (awm_pkg::kind_e'(kind_i))
      awm_pkg::KIND_CLEAR:   acc_clear = accept;
      awm_pkg::KIND_PATTERN: acc_pat   = accept && (plen_q < LW'(PATTERN_MAX));
      awm_pkg::KIND_TEXT:    acc_text  = accept;
      default: ;
    endcase
  end

  assign acc_run = acc_text && (plen_q != '0);

  // window slides once the entering byte makes it full
  assign slide     = ((LW+1)'(fill_q) + (LW+1)'(1)) >= (LW+1)'(plen_q);
  assign slot_sum  = {1'b0, ring_q} + (HW+1)'(fill_q);
  assign slot      = (slot_sum >= (HW+1)'(PATTERN_MAX))
                     ? HW'(slot_sum - (HW+1)'(PATTERN_MAX)) : HW'(slot_sum);
  assign ring_next = (ring_q == HW'(PATTERN_MAX - 1)) ? '0 : ring_q + HW'(1);

  // history ring
  always_ff @(posedge clk_i) begin
    if (acc_run) begin
      hist_mem[slot] <= symbol_i;
      hist_rd_q      <= hist_mem[ring_q];
    end
  end

  // with an empty window the leaving byte is the one just written
  assign leave_sym = s2_fwd_hist_q ? s2_sym_q : hist_rd_q;

  // stage computations on the entry returned by the table
  always_comb begin
    pat_entry.member = 1'b1;
    pat_entry.need   = awm_pkg::sat_inc(cnt_rd.need);
    pat_distinct     = distinct_q;
    pat_matched      = matched_q;
    if (!cnt_rd.member) begin
      pat_distinct = distinct_q + awm_pkg::TOTAL_W'(1);
    end else if ((cnt_rd.need == '0) && (matched_q != '0)) begin
      pat_matched = matched_q - awm_pkg::TOTAL_W'(1);
    end

    txt_entry.member = cnt_rd.member;
    txt_entry.need   = awm_pkg::sat_dec(cnt_rd.need);
    txt_matched      = matched_q;
    if (cnt_rd.member && (txt_entry.need == '0)) begin
      txt_matched = matched_q + awm_pkg::TOTAL_W'(1);
    end
    txt_found = (txt_matched == distinct_q);

    lv_entry.member = cnt_rd.member;
    lv_entry.need   = awm_pkg::sat_inc(cnt_rd.need);
    lv_matched      = matched_q;
    if (cnt_rd.member && (cnt_rd.need == '0) && (matched_q != '0)) begin
      lv_matched = matched_q - awm_pkg::TOTAL_W'(1);
    end
  end

  // count table port: writes from stage 2 or 3, reads from accept or stage 2
  always_comb begin
    cnt_req = '0;
    if (s2_valid_q) begin
      case (s2_op_q)
        OP_PATTERN: begin
          cnt_req.wr_en   = 1'b1;
          cnt_req.wr_addr = s2_sym_q;
          cnt_req.wr_data = pat_entry;
        end
        OP_TEXT: begin
          cnt_req.wr_en   = cnt_rd.member;
          cnt_req.wr_addr = s2_sym_q;
          cnt_req.wr_data = txt_entry;
          cnt_req.rd_en   = s2_leave_q;
          cnt_req.rd_addr = leave_sym;
        end
        default: ;
      endcase
    end else if (s3_valid_q) begin
      cnt_req.wr_en   = cnt_rd.member;
      cnt_req.wr_addr = leave_sym;
      cnt_req.wr_data = lv_entry;
    end
    if (acc_pat || acc_run) begin
      cnt_req.rd_en   = 1'b1;
      cnt_req.rd_addr = symbol_i;
    end
  end

  awm_count_table u_count_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (acc_clear),
    .req_i     (cnt_req),
    .rd_data_o (cnt_rd)
  );

  always_comb begin
    plen_d     = plen_q;
    fill_d     = fill_q;
    ring_d     = ring_q;
    start_d    = start_q;
    matched_d  = matched_q;
    distinct_d = distinct_q;
    if (s2_valid_q) begin
      case (s2_op_q)
        OP_PATTERN: begin
          matched_d  = pat_matched;
          distinct_d = pat_distinct;
        end
        OP_TEXT:    matched_d = txt_matched;
        default: ;
      endcase
    end
    if (s3_valid_q) begin
      matched_d = lv_matched;
    end
    if (acc_pat) begin
      plen_d = plen_q + LW'(1);
    end
    if (acc_run) begin
      if (slide) begin
        ring_d  = ring_next;
        start_d = start_q + awm_pkg::START_W'(1);
      end else begin
        fill_d = fill_q + LW'(1);
      end
    end
    // clear overrides a leaving-byte update finishing this cycle
    if (acc_clear) begin
      plen_d     = '0;
      fill_d     = '0;
      ring_d     = '0;
      start_d    = '0;
      matched_d  = '0;
      distinct_d = '0;
    end
  end

  assign s2_result = s2_valid_q && ((s2_op_q == OP_TEXT) || (s2_op_q == OP_EMPTY));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q      <= '0;
      fill_q      <= '0;
      ring_q      <= '0;
      start_q     <= '0;
      matched_q   <= '0;
      distinct_q  <= '0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      plen_q      <= plen_d;
      fill_q      <= fill_d;
      ring_q      <= ring_d;
      start_q     <= start_d;
      matched_q   <= matched_d;
      distinct_q  <= distinct_d;
      s2_valid_q  <= acc_pat || acc_text;
      s3_valid_q  <= s2_valid_q && (s2_op_q == OP_TEXT) && s2_leave_q;
      if (s2_result) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_op_q       <= acc_pat ? OP_PATTERN : (acc_run ? OP_TEXT : OP_EMPTY);
      s2_sym_q      <= symbol_i;
      s2_leave_q    <= slide;
      s2_fwd_hist_q <= (fill_q == '0);
      s2_start_q    <= start_q;
    end
    if (s2_result) begin
      if (s2_op_q == OP_EMPTY) begin
        out_found_q <= 1'b1;
        out_start_q <= s2_start_q;
      end else begin
        out_found_q <= txt_found;
        out_start_q <= txt_found ? s2_start_q : '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign start_index_o = out_start_q;

  // stage 2 and stage 3 share the table write port
  a_write_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s2_valid_q && s3_valid_q))
    else $error("count table write port claimed twice");

  // a result never lands on an undelivered one
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_result |-> !out_valid_q)
    else $error("output register overrun");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q < plen_q) || ((plen_q == '0) && (fill_q == '0)))
    else $error("window fill out of range");

  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_q <= HW'(PATTERN_MAX - 1))
    else $error("ring head out of range");

endmodule
